### design/fmab_pkg.sv
`default_nettype none
package fmab_pkg;

	// Rounding direction codes
	typedef enum logic [1:0] {
		RM_RNE = 2'd0,
		RM_RTZ = 2'd1,
		RM_RUP = 2'd2,
		RM_RDN = 2'd3
	} rmode_t;

	localparam logic [63:0] DEFAULT_NAN = 64'h7FF8_0000_0000_0000;
	localparam logic [63:0] NEG_ZERO    = 64'h8000_0000_0000_0000;

	// Signed exponent, wide enough for every intermediate scale
	typedef logic signed [13:0] exp_t;

	// Early-resolved result (NaN, infinity, zero cases)
	typedef struct packed {
		logic        hit;
		logic        inv;
		logic [63:0] res;
	} spec_t;

	// Multiplier front end to alignment
	typedef struct packed {
		spec_t        spec;
		logic         ps;
		logic         sc;
		logic         c_zero;
		logic [105:0] prod;
		exp_t         xsum;
		logic [127:0] wc;
		exp_t         ec;
	} mul_out_t;

	// Adder to rounding
	typedef struct packed {
		spec_t        spec;
		logic         neg;
		logic [127:0] r;
		exp_t         e;
	} add_out_t;

	// Final packed beat
	typedef struct packed {
		logic [63:0] res;
		logic        inv;
		logic        ovf;
		logic        unf;
		logic        inx;
	} res_t;

	// Position of the leading one; zero when the word is zero
	function automatic logic [6:0] msb128(input logic [127:0] x);
		logic [6:0] p;
		p = '0;
		for (int i = 0; i < 128; i++) begin
			if (x[i]) p = 7'(i);
		end
		return p;
	endfunction

	// Round-up decision for the directed and nearest modes
	function automatic logic round_inc(input rmode_t m, input logic neg, input logic rb,
			input logic st, input logic lsb);
		logic inc;
		case (m)
			RM_RNE:  inc = rb && (st || lsb);
			RM_RTZ:  inc = 1'b0;
			RM_RUP:  inc = !neg && (rb || st);
			RM_RDN:  inc = neg && (rb || st);
			default: inc = 1'b0;
		endcase
		return inc;
	endfunction

endpackage
`default_nettype wire

### design/fmab_mul.sv
`default_nettype none
// Stages 1-2: operand classification, special results, split mantissa product,
// addend normalization.
module fmab_mul (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire fmab_pkg::rmode_t   rm,
	input  wire logic               in_v,
	output logic                    in_rdy,
	input  wire logic [63:0]        a,
	input  wire logic [63:0]        b,
	input  wire logic [63:0]        c,
	output logic                    out_v,
	input  wire logic               out_rdy,
	output fmab_pkg::mul_out_t      out_d
);

	logic v_s1, v_s2, rdy1, rdy2;

	// Stage handshake: a stage loads when empty or when its beat moves on
	assign rdy2   = !v_s2 || out_rdy;
	assign rdy1   = !v_s1 || rdy2;
	assign in_rdy = rdy1;
	assign out_v  = v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_v;
			if (rdy2) v_s2 <= v_s1;
		end
	end

	// Stage 1 classification
	logic [10:0] ea, eb, ecx;
	logic a_nan, b_nan, c_nan, a_inf, b_inf, c_inf, a_zero, b_zero, c_zero;
	logic ps, sc;
	fmab_pkg::spec_t spec_d;

	always_comb begin
		ea     = a[62:52];
		eb     = b[62:52];
		ecx    = c[62:52];
		a_nan  = (&ea) && (|a[51:0]);
		b_nan  = (&eb) && (|b[51:0]);
		c_nan  = (&ecx) && (|c[51:0]);
		a_inf  = (&ea) && !(|a[51:0]);
		b_inf  = (&eb) && !(|b[51:0]);
		c_inf  = (&ecx) && !(|c[51:0]);
		a_zero = (a[62:0] == 63'd0);
		b_zero = (b[62:0] == 63'd0);
		c_zero = (c[62:0] == 63'd0);
		ps     = a[63] ^ b[63];
		sc     = c[63];
		spec_d = '{hit: 1'b1, inv: 1'b0, res: 64'd0};
		if (a_nan) begin
			spec_d.res = a;
		end else if (b_nan) begin
			spec_d.res = b;
		end else if ((a_zero && b_inf) || (b_zero && a_inf)) begin
			spec_d.inv = 1'b1;
			spec_d.res = c_nan ? c : fmab_pkg::DEFAULT_NAN;
		end else if (c_nan) begin
			spec_d.res = c;
		end else if (a_inf || b_inf) begin
			if (c_inf && (sc != ps)) begin
				spec_d.inv = 1'b1;
				spec_d.res = fmab_pkg::DEFAULT_NAN;
			end else begin
				spec_d.res = {ps, 11'h7FF, 52'd0};
			end
		end else if (c_inf) begin
			spec_d.res = c;
		end else if (a_zero || b_zero) begin
			if (!c_zero) spec_d.res = c;
			else if (ps == sc) spec_d.res = {ps, 63'd0};
			else spec_d.res = (rm == fmab_pkg::RM_RDN) ? fmab_pkg::NEG_ZERO : 64'd0;
		end else begin
			spec_d.hit = 1'b0;
		end
	end

	// Stage 1 decode and partial products (27-bit low halves, 26-bit high halves)
	logic [52:0] ma, mb, mc;
	fmab_pkg::exp_t xa, xb, ecd;
	logic [53:0] pp00_d, pp01_d, pp10_d, pp11_d;

	always_comb begin
		ma     = {(ea != 11'd0), a[51:0]};
		mb     = {(eb != 11'd0), b[51:0]};
		mc     = {(ecx != 11'd0), c[51:0]};
		xa     = fmab_pkg::exp_t'({3'd0, (ea == 11'd0) ? 11'd1 : ea}) - 14'sd1075;
		xb     = fmab_pkg::exp_t'({3'd0, (eb == 11'd0) ? 11'd1 : eb}) - 14'sd1075;
		ecd    = fmab_pkg::exp_t'({3'd0, (ecx == 11'd0) ? 11'd1 : ecx}) - 14'sd1075;
		pp00_d = 54'(ma[26:0]) * 54'(mb[26:0]);
		pp01_d = 54'(ma[26:0]) * 54'(mb[52:27]);
		pp10_d = 54'(ma[52:27]) * 54'(mb[26:0]);
		pp11_d = 54'(ma[52:27]) * 54'(mb[52:27]);
	end

	fmab_pkg::spec_t spec_s1;
	logic ps_s1, sc_s1, cz_s1;
	logic [53:0] pp00_s1, pp01_s1, pp10_s1, pp11_s1;
	fmab_pkg::exp_t xsum_s1, ec_s1;
	logic [52:0] mc_s1;

	always_ff @(posedge clk) begin
		if (rdy1) begin
			spec_s1 <= spec_d;
			ps_s1   <= ps;
			sc_s1   <= sc;
			cz_s1   <= c_zero;
			pp00_s1 <= pp00_d;
			pp01_s1 <= pp01_d;
			pp10_s1 <= pp10_d;
			pp11_s1 <= pp11_d;
			xsum_s1 <= xa + xb;
			ec_s1   <= ecd;
			mc_s1   <= mc;
		end
	end

	// Stage 2: sum partial products, normalize addend to bit 124
	logic [105:0] prod_d;
	logic [6:0]   mcm, shc;
	logic [127:0] wc_d;

	always_comb begin
		prod_d = 106'(pp00_s1) + (106'(pp01_s1) << 27) + (106'(pp10_s1) << 27)
			+ (106'(pp11_s1) << 54);
		mcm    = fmab_pkg::msb128({75'd0, mc_s1});
		shc    = 7'd124 - mcm;
		wc_d   = {75'd0, mc_s1} << shc;
	end

	always_ff @(posedge clk) begin
		if (rdy2) begin
			out_d.spec   <= spec_s1;
			out_d.ps     <= ps_s1;
			out_d.sc     <= sc_s1;
			out_d.c_zero <= cz_s1;
			out_d.prod   <= prod_d;
			out_d.xsum   <= xsum_s1;
			out_d.wc     <= wc_d;
			out_d.ec     <= ec_s1 - fmab_pkg::exp_t'({7'd0, shc});
		end
	end

endmodule
`default_nettype wire

### design/fmab_align.sv
`default_nettype none
// Stages 3-5: product normalization, alignment with sticky, add/subtract.
module fmab_align (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire fmab_pkg::rmode_t   rm,
	input  wire logic               in_v,
	output logic                    in_rdy,
	input  wire fmab_pkg::mul_out_t in_d,
	output logic                    out_v,
	input  wire logic               out_rdy,
	output fmab_pkg::add_out_t      out_d
);

	logic v_s3, v_s4, v_s5, rdy3, rdy4, rdy5;

	assign rdy5   = !v_s5 || out_rdy;
	assign rdy4   = !v_s4 || rdy5;
	assign rdy3   = !v_s3 || rdy4;
	assign in_rdy = rdy3;
	assign out_v  = v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy3) v_s3 <= in_v;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	// Stage 3: bring the product's leading one to bit 124
	logic [6:0] pm, shp;

	always_comb begin
		pm  = fmab_pkg::msb128({22'd0, in_d.prod});
		shp = 7'd124 - pm;
	end

	fmab_pkg::spec_t spec_s3;
	logic ps_s3, sc_s3, cz_s3;
	logic [127:0] prod_s3, wc_s3;
	fmab_pkg::exp_t ep_s3, ec_s3;

	always_ff @(posedge clk) begin
		if (rdy3) begin
			spec_s3 <= in_d.spec;
			ps_s3   <= in_d.ps;
			sc_s3   <= in_d.sc;
			cz_s3   <= in_d.c_zero;
			prod_s3 <= {22'd0, in_d.prod} << shp;
			ep_s3   <= in_d.xsum - fmab_pkg::exp_t'({7'd0, shp});
			wc_s3   <= in_d.wc;
			ec_s3   <= in_d.ec;
		end
	end

	// Stage 4: swap, align the smaller operand, fold shifted-out bits to sticky
	logic swap, stk;
	logic [127:0] big, small_v, small_sh;
	fmab_pkg::exp_t dd, e4;
	logic [7:0] dsh;

	always_comb begin
		swap     = !cz_s3 && (ec_s3 > ep_s3);
		big      = swap ? wc_s3 : prod_s3;
		small_v  = cz_s3 ? 128'd0 : (swap ? prod_s3 : wc_s3);
		dd       = swap ? (ec_s3 - ep_s3) : (ep_s3 - ec_s3);
		dsh      = (dd > 14'sd128) ? 8'd128 : dd[7:0];
		stk      = |(small_v & ~({128{1'b1}} << dsh));
		small_sh = small_v >> dsh;
		e4       = (swap ? ec_s3 : ep_s3) - 14'sd1;
	end

	fmab_pkg::spec_t spec_s4;
	logic bneg_s4, sneg_s4;
	logic [127:0] big_s4, small_s4;
	fmab_pkg::exp_t e_s4;

	always_ff @(posedge clk) begin
		if (rdy4) begin
			spec_s4  <= spec_s3;
			bneg_s4  <= swap ? sc_s3 : ps_s3;
			sneg_s4  <= swap ? ps_s3 : sc_s3;
			big_s4   <= {big[126:0], 1'b0};
			small_s4 <= {small_sh[126:0], stk};
			e_s4     <= e4;
		end
	end

	// Stage 5: magnitude add or subtract
	logic lt, neg5;
	logic [127:0] r5;
	fmab_pkg::spec_t spec5;

	always_comb begin
		lt    = big_s4 < small_s4;
		spec5 = spec_s4;
		if (bneg_s4 == sneg_s4) begin
			r5   = big_s4 + small_s4;
			neg5 = bneg_s4;
		end else if (lt) begin
			r5   = small_s4 - big_s4;
			neg5 = sneg_s4;
		end else begin
			r5   = big_s4 - small_s4;
			neg5 = bneg_s4;
		end
		// exact cancellation
		if (!spec_s4.hit && (r5 == 128'd0)) begin
			spec5.hit = 1'b1;
			spec5.inv = 1'b0;
			spec5.res = (rm == fmab_pkg::RM_RDN) ? fmab_pkg::NEG_ZERO : 64'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy5) begin
			out_d.spec <= spec5;
			out_d.neg  <= neg5;
			out_d.r    <= r5;
			out_d.e    <= e_s4;
		end
	end

endmodule
`default_nettype wire

### design/fmab_round.sv
`default_nettype none
// Stages 6-8: leading-one search, rounding, exponent pack and flags.
module fmab_round (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire fmab_pkg::rmode_t   rm,
	input  wire logic               in_v,
	output logic                    in_rdy,
	input  wire fmab_pkg::add_out_t in_d,
	output logic                    out_v,
	input  wire logic               out_rdy,
	output fmab_pkg::res_t          out_d
);

	logic v_s6, v_s7, v_s8, rdy6, rdy7, rdy8;

	assign rdy8   = !v_s8 || out_rdy;
	assign rdy7   = !v_s7 || rdy8;
	assign rdy6   = !v_s6 || rdy7;
	assign in_rdy = rdy6;
	assign out_v  = v_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			if (rdy6) v_s6 <= in_v;
			if (rdy7) v_s7 <= v_s6;
			if (rdy8) v_s8 <= v_s7;
		end
	end

	// Stage 6: rounding position, limited below by the subnormal floor
	logic [6:0] p6;
	fmab_pkg::exp_t sa, sb;

	always_comb begin
		p6 = fmab_pkg::msb128(in_d.r);
		sa = fmab_pkg::exp_t'({7'd0, p6}) - 14'sd52;
		sb = -14'sd1074 - in_d.e;
	end

	fmab_pkg::spec_t spec_s6;
	logic neg_s6;
	logic [127:0] r_s6;
	fmab_pkg::exp_t e_s6, s_s6, top_s6;

	always_ff @(posedge clk) begin
		if (rdy6) begin
			spec_s6 <= in_d.spec;
			neg_s6  <= in_d.neg;
			r_s6    <= in_d.r;
			e_s6    <= in_d.e;
			s_s6    <= (sb > sa) ? sb : sa;
			top_s6  <= fmab_pkg::exp_t'({7'd0, p6}) + in_d.e;
		end
	end

	// Stage 7: cut at s, round; also test whether 53-bit rounding carries
	logic [7:0] sc7;
	logic [127:0] sh_q, sh_rb, sh_rb2;
	logic [52:0] q7;
	logic rb, st, rb2, st2, inc, inc2, ix7, cy2;
	logic [53:0] qr7;
	logic [5:0] lsh;

	always_comb begin
		sc7    = (s_s6 > 14'sd129) ? 8'd129 : s_s6[7:0];
		lsh    = 6'(-s_s6);
		sh_q   = r_s6 >> sc7;
		sh_rb  = r_s6 >> (sc7 - 8'd1);
		sh_rb2 = r_s6 >> (sc7 - 8'd2);
		rb     = sh_rb[0];
		st     = |(r_s6 & ~({128{1'b1}} << (sc7 - 8'd1)));
		rb2    = sh_rb2[0];
		st2    = |(r_s6 & ~({128{1'b1}} << (sc7 - 8'd2)));
		q7     = sh_q[52:0];
		inc    = fmab_pkg::round_inc(rm, neg_s6, rb, st, q7[0]);
		inc2   = fmab_pkg::round_inc(rm, neg_s6, rb2, st2, rb);
		if (s_s6 <= 14'sd0) begin
			qr7 = {1'b0, r_s6[52:0] << lsh};
			ix7 = 1'b0;
			cy2 = 1'b0;
		end else begin
			qr7 = {1'b0, q7} + 54'(inc);
			ix7 = rb | st;
			cy2 = (s_s6 >= 14'sd2) && (&q7[51:0]) && rb && inc2;
		end
	end

	fmab_pkg::spec_t spec_s7;
	logic neg_s7, ix_s7, cy2_s7;
	logic [53:0] qr_s7;
	fmab_pkg::exp_t lsb_s7, top_s7;

	always_ff @(posedge clk) begin
		if (rdy7) begin
			spec_s7 <= spec_s6;
			neg_s7  <= neg_s6;
			ix_s7   <= ix7;
			cy2_s7  <= cy2;
			qr_s7   <= qr7;
			lsb_s7  <= e_s6 + s_s6;
			top_s7  <= top_s6;
		end
	end

	// Stage 8: renormalize carry-out, pack, overflow and underflow
	logic [52:0] q8;
	fmab_pkg::exp_t biased;
	logic to_inf;
	fmab_pkg::res_t res8;

	always_comb begin
		q8     = qr_s7[53] ? qr_s7[53:1] : qr_s7[52:0];
		biased = lsb_s7 + fmab_pkg::exp_t'({13'd0, qr_s7[53]}) + 14'sd1075;
		to_inf = (rm == fmab_pkg::RM_RNE) || ((rm == fmab_pkg::RM_RUP) && !neg_s7)
			|| ((rm == fmab_pkg::RM_RDN) && neg_s7);
		res8.inv = 1'b0;
		res8.ovf = 1'b0;
		res8.inx = ix_s7;
		res8.unf = ix_s7 && (top_s7 < -14'sd1022) && !((top_s7 == -14'sd1023) && cy2_s7);
		if (!q8[52]) begin
			res8.res = {neg_s7, 11'd0, q8[51:0]};
		end else if (biased >= 14'sd2047) begin
			res8.ovf = 1'b1;
			res8.inx = 1'b1;
			res8.res = to_inf ? {neg_s7, 11'h7FF, 52'd0} : {neg_s7, 11'h7FE, {52{1'b1}}};
		end else begin
			res8.res = {neg_s7, biased[10:0], q8[51:0]};
		end
		if (spec_s7.hit) begin
			res8.res = spec_s7.res;
			res8.inv = spec_s7.inv;
			res8.ovf = 1'b0;
			res8.unf = 1'b0;
			res8.inx = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy8) out_d <= res8;
	end

endmodule
`default_nettype wire

### design/fused_multiply_add_binary64.sv
`default_nettype none
// Binary64 fused multiply-add: sum_result = round(operand_a * operand_b + operand_c),
// one rounding, with IEEE invalid/overflow/underflow/inexact flags.
//
// Input channel: in_valid / in_stall. A beat is taken on a clock edge with in_valid
// high and in_stall low. Output channel: out_valid / out_stall, same rule.
// Configuration: cfg_valid / cfg_ready / cfg_data carries the 2-bit rounding mode
// (0 nearest-even, 1 toward zero, 2 toward +inf, 3 toward -inf). cfg_ready is
// always high; write it only while no beat is in flight.
//
// Throughput is one beat per cycle while out_stall stays low. The eight stages are:
// decode + split partial products (27-bit and 26-bit halves), product sum, product
// normalize, align, add, leading-one search, round, pack.
// Each stage advances when it is empty or its successor moves, so a stalled output
// holds its beat while bubbles ahead of it still fill; in_stall rises only once
// every stage is occupied.
// Reset clears all stage valid bits and sets round-to-nearest-even.
module fused_multiply_add_binary64 (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [63:0] operand_a,
	input  wire logic [63:0] operand_b,
	input  wire logic [63:0] operand_c,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [63:0]      sum_result,
	output logic             invalid_flag,
	output logic             overflow_flag,
	output logic             underflow_flag,
	output logic             inexact_flag
);

	fmab_pkg::rmode_t rm_q;

	// Rounding mode register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rm_q <= fmab_pkg::RM_RNE;
		else if (cfg_valid && cfg_ready) rm_q <= fmab_pkg::rmode_t'(cfg_data);
	end

	logic mul_rdy, mul_v, add_rdy, add_v, rnd_rdy;
	fmab_pkg::mul_out_t mul_d;
	fmab_pkg::add_out_t add_d;
	fmab_pkg::res_t     res_d;

	fmab_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.rm     (rm_q),
		.in_v   (in_valid),
		.in_rdy (mul_rdy),
		.a      (operand_a),
		.b      (operand_b),
		.c      (operand_c),
		.out_v  (mul_v),
		.out_rdy(add_rdy),
		.out_d  (mul_d)
	);

	fmab_align u_align (
		.clk    (clk),
		.arst_n (arst_n),
		.rm     (rm_q),
		.in_v   (mul_v),
		.in_rdy (add_rdy),
		.in_d   (mul_d),
		.out_v  (add_v),
		.out_rdy(rnd_rdy),
		.out_d  (add_d)
	);

	fmab_round u_round (
		.clk    (clk),
		.arst_n (arst_n),
		.rm     (rm_q),
		.in_v   (add_v),
		.in_rdy (rnd_rdy),
		.in_d   (add_d),
		.out_v  (out_valid),
		.out_rdy(!out_stall),
		.out_d  (res_d)
	);

	assign in_stall       = !mul_rdy;
	assign sum_result     = res_d.res;
	assign invalid_flag   = res_d.inv;
	assign overflow_flag  = res_d.ovf;
	assign underflow_flag = res_d.unf;
	assign inexact_flag   = res_d.inx;

	// An invalid beat always carries a NaN
	a_inv_nan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && invalid_flag |-> (&sum_result[62:52]) && (|sum_result[51:0]))
		else $error("invalid flag without NaN result");

	// Overflow and underflow both imply inexact
	a_ovf_inx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (overflow_flag || underflow_flag) |-> inexact_flag)
		else $error("overflow/underflow without inexact");

	// Overflow result is infinity or the largest finite magnitude
	a_ovf_val: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow_flag |-> (sum_result[62:0] == 63'h7FF0_0000_0000_0000)
			|| (sum_result[62:0] == 63'h7FEF_FFFF_FFFF_FFFF))
		else $error("overflow result not saturated");

endmodule
`default_nettype wire
